FILE: rtl/core/u8d_pkg.sv
// types, constants and helpers shared by the utf-8 stream decoder core
// no dependencies
package u8d_pkg;

    localparam int unsigned CpW      = 21;
    localparam int unsigned BufDepth = 4;
    localparam int unsigned CntW     = 3;

    localparam logic [CpW-1:0] CpReplace = 21'h00FFFF;
    localparam logic [CpW-1:0] CpMin2    = 21'h000080;
    localparam logic [CpW-1:0] CpMin3    = 21'h000800;
    localparam logic [CpW-1:0] CpMax3    = 21'h00FFFF;

    localparam logic [7:0] ContMask  = 8'hC0;
    localparam logic [7:0] ContTag   = 8'h80;
    localparam logic [7:0] Lead2Mask = 8'hE0;
    localparam logic [7:0] Lead2Tag  = 8'hC0;
    localparam logic [7:0] Lead3Mask = 8'hF0;
    localparam logic [7:0] Lead3Tag  = 8'hE0;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_buffer;
    } t_in_item;

    typedef struct packed {
        logic [CpW-1:0] code_point;
        logic           is_invalid;
        logic           last_of_run;
    } t_out_item;

    typedef enum logic {
        S_IDLE,
        S_DECODE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic append;     // take the accepted byte into the buffer
        logic step;       // retire the front sequence into the hold register
        logic push;       // move the hold register to the output register
        logic push_last;  // mark the pushed result as the last of its run
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic empty;      // no bytes buffered
        logic wait_more;  // front sequence incomplete, more bytes needed
        logic hold_v;     // a result waits in the hold register
        logic out_free;   // output register can take a result this cycle
    } t_status;

    function automatic logic is_cont(input logic [7:0] b);
        return (b & ContMask) == ContTag;
    endfunction

endpackage

FILE: rtl/core/u8d_if.sv
// stream channel interfaces for the utf-8 decoder input and output
// depends on u8d_pkg for the payload types
interface u8d_in_if;
    logic               valid;
    logic               ready;
    u8d_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface u8d_out_if;
    logic               valid;
    logic               ready;
    u8d_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/utf8_stream_decoder_core.sv
// utf-8 stream decoder core: one byte per input transfer, code points out
// a byte is taken while idle; the decode loop then retires each result it settles
// into the hold register and pushes it on when the output register is free
// no new byte is taken until the decode loop ends; the datapath has a single evaluator
// reset: synchronous active-low i_rst_n clears the buffer count, the state and valids
// depends on u8d_pkg, u8d_if, u8d_ctrl, u8d_datapath
module utf8_stream_decoder_core (
    input  logic   i_clk,
    input  logic   i_rst_n,
    u8d_in_if.sink    i_in,
    u8d_out_if.source o_out
);
    import u8d_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    in_ready;

    // controller: accepts a byte when idle, then steps the decode loop;
    // each result waits in a hold register until the next evaluation shows
    // whether another result follows, which sets last_of_run
    u8d_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // datapath: up to four buffered bytes, evaluator, hold and output register;
    // the output register lets the next byte transfer in while a result waits
    u8d_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in.data),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_data  (o_out.data)
    );

    assign i_in.ready = in_ready;
endmodule

FILE: rtl/core/u8d_datapath.sv
// byte buffer, front sequence evaluation, hold and output registers
// depends on u8d_pkg
module u8d_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  u8d_pkg::t_in_item   i_in_data,
    input  u8d_pkg::t_cmd       i_cmd,
    output u8d_pkg::t_status    o_status,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output u8d_pkg::t_out_item  o_out_data
);
    import u8d_pkg::*;

    logic [7:0]     r_buf [BufDepth];
    logic [7:0]     n_buf [BufDepth];
    logic [CntW-1:0] r_cnt;
    logic [CntW-1:0] n_cnt;
    logic           r_eob;
    logic [CpW-1:0] r_hold_cp;
    logic           r_hold_inv;
    logic           r_hold_v;
    t_out_item      r_out;
    logic           r_out_v;

    // front sequence evaluation
    logic [7:0]     lead;
    logic [CntW-1:0] need;
    logic [CntW-1:0] use_n;
    logic           miss;
    logic           shrt;
    logic           bad;
    logic           wait_more;
    logic           empty;
    logic [CpW-1:0] cp;
    logic [CpW-1:0] res_cp;

    always_comb begin
        lead      = r_buf[0];
        empty     = (r_cnt == '0);
        wait_more = 1'b0;
        bad       = 1'b0;
        cp        = {13'b0, lead};
        use_n     = CntW'(1);
        miss      = 1'b0;

        if ((lead & Lead2Mask) == Lead2Tag) begin
            need = CntW'(2);
        end else if ((lead & Lead3Mask) == Lead3Tag) begin
            need = CntW'(3);
        end else begin
            need = CntW'(4);
        end
        // first non-continuation among the bytes present settles it as bad
        for (int j = 1; j < BufDepth; j++) begin
            if (CntW'(j) < need && CntW'(j) < r_cnt && !is_cont(r_buf[j])) begin
                miss = 1'b1;
            end
        end
        shrt = (r_cnt < need);

        if (empty) begin
            bad = 1'b0;
        end else if (!lead[7]) begin
            cp = {13'b0, lead};
        end else if (is_cont(lead)) begin
            bad = 1'b1;
        end else if (miss) begin
            bad = 1'b1;
        end else if (shrt) begin
            if (r_eob) begin
                bad = 1'b1;
            end else begin
                wait_more = 1'b1;
            end
        end else begin
            unique case (need)
                CntW'(2): begin
                    cp  = {10'b0, lead[4:0], r_buf[1][5:0]};
                    bad = cp < CpMin2;
                end
                CntW'(3): begin
                    cp  = {5'b0, lead[3:0], r_buf[1][5:0], r_buf[2][5:0]};
                    bad = cp < CpMin3;
                end
                default: begin
                    cp  = {lead[2:0], r_buf[1][5:0], r_buf[2][5:0], r_buf[3][5:0]};
                    bad = cp <= CpMax3;
                end
            endcase
            if (cp == CpReplace) begin
                bad = 1'b1;
            end
            if (!bad) begin
                use_n = need;
            end
        end
        res_cp = bad ? CpReplace : cp;
    end

    // buffer shift by the consumed length, or append of a new byte
    always_comb begin
        for (int i = 0; i < BufDepth; i++) begin
            n_buf[i] = r_buf[i];
        end
        n_cnt = r_cnt;
        if (i_cmd.append) begin
            n_buf[r_cnt[1:0]] = i_in_data.in_byte;
            n_cnt             = r_cnt + CntW'(1);
        end else if (i_cmd.step) begin
            for (int i = 0; i < BufDepth; i++) begin
                if (CntW'(i) + use_n < CntW'(BufDepth)) begin
                    n_buf[i] = r_buf[2'(CntW'(i) + use_n)];
                end
            end
            n_cnt = r_cnt - use_n;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < BufDepth; i++) begin
            r_buf[i] <= n_buf[i];
        end
        if (i_cmd.append) begin
            r_eob <= i_in_data.end_of_buffer;
        end
        if (i_cmd.step) begin
            r_hold_cp  <= res_cp;
            r_hold_inv <= bad;
        end
        if (i_cmd.push) begin
            r_out.code_point  <= r_hold_cp;
            r_out.is_invalid  <= r_hold_inv;
            r_out.last_of_run <= i_cmd.push_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (i_cmd.step) begin
                r_hold_v <= 1'b1;
            end else if (i_cmd.push) begin
                r_hold_v <= 1'b0;
            end
            if (i_cmd.push) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_status.empty     = empty;
    assign o_status.wait_more = wait_more;
    assign o_status.hold_v    = r_hold_v;
    assign o_status.out_free  = !r_out_v || i_out_ready;
    assign o_out_valid        = r_out_v;
    assign o_out_data         = r_out;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntW'(BufDepth))
        else $error("buffer count out of range");

    a_push_needs_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> r_hold_v && (!r_out_v || i_out_ready))
        else $error("push without a held result or with a full output");

    a_step_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> !empty && !wait_more)
        else $error("step on an empty or incomplete buffer");

    a_append_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.append |=> r_cnt != '0)
        else $error("append left the buffer empty");
endmodule

FILE: rtl/core/u8d_ctrl.sv
// controller state machine: input transfer, decode loop and result pushes
// depends on u8d_pkg
module u8d_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  u8d_pkg::t_status  i_status,
    output u8d_pkg::t_cmd     o_cmd
);
    import u8d_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   done;

    assign done = i_status.empty || i_status.wait_more;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (done && (!i_status.hold_v || i_status.out_free)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.append = i_in_valid;
            end
            S_DECODE: begin
                if (!done) begin
                    // new result: the held one is known not to be last
                    if (!i_status.hold_v) begin
                        o_cmd.step = 1'b1;
                    end else if (i_status.out_free) begin
                        o_cmd.step = 1'b1;
                        o_cmd.push = 1'b1;
                    end
                end else if (i_status.hold_v && i_status.out_free) begin
                    o_cmd.push      = 1'b1;
                    o_cmd.push_last = 1'b1;
                end
            end
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !i_status.hold_v)
        else $error("idle with a result still held");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.push && o_cmd.push_last |=> r_state == S_IDLE)
        else $error("last result pushed but decode continues");

    a_append_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.append |-> r_state == S_IDLE && !o_cmd.step && !o_cmd.push)
        else $error("append overlaps decode");
endmodule
